@@ rtl/core/hop_channel_list_generator_unit_defines.svh @@
// Assertion macros for the hop channel list generator.
`ifndef HOP_CHANNEL_LIST_GENERATOR_UNIT_DEFINES_SVH
`define HOP_CHANNEL_LIST_GENERATOR_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define HCL_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hcl assertion failed");

`define HCL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hcl assertion failed");

`else

`define HCL_ASSERT_IMPL(label, clk, rst_n, ante, cons)

`define HCL_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/core/hcl_pkg.sv @@
// Shared types and constants for the hop channel list generator.
`timescale 1ns / 1ps
package hcl_pkg;

    localparam int HOP_LENGTH  = 23;
    localparam int TABLE_DEPTH = 23;
    localparam int IDX_W       = 5;
    localparam int CH_W        = 7;

    localparam logic [20:0] LCG_MUL  = 21'h19660D;
    localparam logic [31:0] LCG_ADD  = 32'h3C6EF35F;
    // floor(2^24 / 73): quotient estimate is exact or one low
    localparam logic [17:0] RECIP_M  = 18'd229824;
    localparam logic [7:0]  CH_SPAN  = 8'h49;
    localparam logic [6:0]  CH_BASE  = 7'd3;
    localparam logic [6:0]  LOW_TOP  = 7'd27;
    localparam logic [6:0]  MID_TOP  = 7'd51;
    localparam logic [3:0]  OUTER_LIM = 4'd8;
    localparam logic [3:0]  MID_LIM   = 4'd7;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HOP_LENGTH - 1);
    localparam logic [IDX_W-1:0] FULL_CNT = IDX_W'(HOP_LENGTH);

    typedef struct packed {
        logic load;
        logic step;
        logic recip;
        logic reduce;
        logic check;
        logic emit;
    } hcl_cmd_t;

    typedef struct packed {
        logic full;
        logic emit_last;
    } hcl_status_t;

endpackage

@@ rtl/core/hcl_datapath.sv @@
// Datapath: generator, channel reduction, list checks, hop table and output register.
`timescale 1ns / 1ps
module hcl_datapath
    import hcl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  hcl_cmd_t           cmd,
    input  logic [31:0]        seed_id,
    output hcl_status_t        status,
    output logic [CH_W-1:0]    out_channel,
    output logic [IDX_W-1:0]   out_slot,
    output logic               out_last
);

    logic [31:0]      gen_state_reg, gen_state_next;
    logic             parity_reg, parity_next;
    logic [17:0]      q_reg, q_next;
    logic [7:0]       rem_reg, rem_next;
    logic [IDX_W-1:0] filled_reg, filled_next;
    logic [IDX_W-1:0] emit_idx_reg, emit_idx_next;
    logic [3:0]       n_low_reg, n_low_next;
    logic [3:0]       n_mid_reg, n_mid_next;
    logic [3:0]       n_high_reg, n_high_next;
    logic [CH_W-1:0]  hop_tbl_reg [TABLE_DEPTH];
    logic [CH_W-1:0]  out_channel_reg;
    logic [IDX_W-1:0] out_slot_reg;
    logic             out_last_reg;

    logic [52:0] lcg_prod;
    logic [41:0] recip_prod;
    logic [23:0] q_mul;
    logic [23:0] diff;
    logic [7:0]  rem_adj;
    logic [CH_W-1:0] ch;
    logic dup;
    logic room;
    logic is_low;
    logic is_mid;
    logic take;

    always_comb
    begin
        lcg_prod   = 53'(gen_state_reg) * 53'(LCG_MUL);
        recip_prod = 42'(gen_state_reg[31:8]) * 42'(RECIP_M);
        q_mul      = 24'(q_reg) * 24'(CH_SPAN);
        diff       = gen_state_reg[31:8] - q_mul;
        rem_adj    = (rem_reg >= CH_SPAN) ? (rem_reg - CH_SPAN) : rem_reg;
        ch         = rem_adj[CH_W-1:0] + CH_BASE;
        is_low     = (ch <= LOW_TOP);
        is_mid     = !is_low && (ch <= MID_TOP);
        dup        = 1'b0;
        for (int k = 0; k < TABLE_DEPTH; k++)
        begin
            if ((IDX_W'(k) < filled_reg) && (hop_tbl_reg[k] == ch))
            begin
                dup = 1'b1;
            end
        end
        if (is_low)
        begin
            room = (n_low_reg < OUTER_LIM);
        end
        else if (is_mid)
        begin
            room = (n_mid_reg < MID_LIM);
        end
        else
        begin
            room = (n_high_reg < OUTER_LIM);
        end
        take = cmd.check && (ch[0] != parity_reg) && !dup && room;
    end

    always_comb
    begin
        gen_state_next = gen_state_reg;
        parity_next    = parity_reg;
        q_next         = q_reg;
        rem_next       = rem_reg;
        filled_next    = filled_reg;
        emit_idx_next  = emit_idx_reg;
        n_low_next     = n_low_reg;
        n_mid_next     = n_mid_reg;
        n_high_next    = n_high_reg;
        if (cmd.load)
        begin
            gen_state_next = ~seed_id;
            parity_next    = ~seed_id[0];
            filled_next    = '0;
            emit_idx_next  = '0;
            n_low_next     = '0;
            n_mid_next     = '0;
            n_high_next    = '0;
        end
        if (cmd.step)
        begin
            gen_state_next = lcg_prod[31:0] + LCG_ADD;
        end
        if (cmd.recip)
        begin
            q_next = recip_prod[41:24];
        end
        if (cmd.reduce)
        begin
            rem_next = diff[7:0];
        end
        if (take)
        begin
            filled_next = filled_reg + 1'b1;
            if (is_low)
            begin
                n_low_next = n_low_reg + 1'b1;
            end
            else if (is_mid)
            begin
                n_mid_next = n_mid_reg + 1'b1;
            end
            else
            begin
                n_high_next = n_high_reg + 1'b1;
            end
        end
        if (cmd.emit)
        begin
            emit_idx_next = emit_idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen_state_reg <= '0;
            parity_reg    <= 1'b0;
            q_reg         <= '0;
            rem_reg       <= '0;
            filled_reg    <= '0;
            emit_idx_reg  <= '0;
            n_low_reg     <= '0;
            n_mid_reg     <= '0;
            n_high_reg    <= '0;
        end
        else
        begin
            gen_state_reg <= gen_state_next;
            parity_reg    <= parity_next;
            q_reg         <= q_next;
            rem_reg       <= rem_next;
            filled_reg    <= filled_next;
            emit_idx_reg  <= emit_idx_next;
            n_low_reg     <= n_low_next;
            n_mid_reg     <= n_mid_next;
            n_high_reg    <= n_high_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            hop_tbl_reg[filled_reg] <= ch;
        end
        if (cmd.emit)
        begin
            out_channel_reg <= hop_tbl_reg[emit_idx_reg];
            out_slot_reg    <= emit_idx_reg;
            out_last_reg    <= (emit_idx_reg == LAST_IDX);
        end
    end

    assign status.full      = (filled_reg == FULL_CNT);
    assign status.emit_last = (emit_idx_reg == LAST_IDX);
    assign out_channel      = out_channel_reg;
    assign out_slot         = out_slot_reg;
    assign out_last         = out_last_reg;

endmodule

@@ rtl/core/hcl_ctrl.sv @@
// Controller: sequences generator steps, candidate checks and list emission.
`timescale 1ns / 1ps
module hcl_ctrl
    import hcl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    output logic        out_valid,
    input  logic        out_ready,
    input  hcl_status_t status,
    output hcl_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STEP,
        ST_RECIP,
        ST_REDUCE,
        ST_CHECK,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        in_ready       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_STEP;
                end
            end
            ST_STEP:
            begin
                if (status.full)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    cmd.step   = 1'b1;
                    state_next = ST_RECIP;
                end
            end
            ST_RECIP:
            begin
                cmd.recip  = 1'b1;
                state_next = ST_REDUCE;
            end
            ST_REDUCE:
            begin
                cmd.reduce = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                cmd.check  = 1'b1;
                state_next = ST_STEP;
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    if (status.emit_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

@@ rtl/core/hop_channel_list_generator_unit.sv @@
// Top level of the hop channel list generator.
//
//   channel   dir   tdata fields (lsb first)                 tlast
//   s_*       in    transmitter_id[31:0]                     -
//   m_*       out   hop_channel[6:0], slot_index[11:7], 0s   last_slot
//
// Each candidate passes through four steps: generator step (one 32x21 multiply), reciprocal
// multiply, remainder, and list check (parallel duplicate compare over the table).
// A list goes through load, the candidates, the final full check, then emission of one slot
// per cycle while m_tready keeps the output register free.
// The input is taken only when idle; the output register holds while m_tready is low
// and emission stalls behind it.
// Reset clears control and generator state; the hop table is not cleared.
`timescale 1ns / 1ps
`include "hop_channel_list_generator_unit_defines.svh"
module hop_channel_list_generator_unit
    import hcl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // transmitter_id[31:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // hop_channel[6:0], slot_index[11:7], zero[15:12]
    output logic        m_tlast
);

    hcl_cmd_t         cmd;
    hcl_status_t      status;
    logic [CH_W-1:0]  out_channel;
    logic [IDX_W-1:0] out_slot;
    logic             out_last;

    hcl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .status    (status),
        .cmd       (cmd)
    );

    hcl_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .seed_id     (s_tdata),
        .status      (status),
        .out_channel (out_channel),
        .out_slot    (out_slot),
        .out_last    (out_last)
    );

    assign m_tdata = {4'b0000, out_slot, out_channel};
    assign m_tlast = out_last;

    `HCL_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, s_tvalid && s_tready, !s_tready)
    `HCL_ASSERT_IMPL(a_last_slot, clk, rst_n, m_tvalid && m_tlast, out_slot == LAST_IDX)
    `HCL_ASSERT_IMPL(a_chan, clk, rst_n, m_tvalid, (out_channel >= 7'd3) && (out_channel <= 7'd75))

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the hop channel list generator unit.
`timescale 1ns / 1ps
module testbench;
    import hcl_pkg::*;

    typedef struct packed {
        logic [CH_W-1:0]  channel;
        logic [IDX_W-1:0] slot;
        logic             last;
    } hop_slot_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;      // transmitter_id[31:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;           // hop_channel[6:0], slot_index[11:7], zero[15:12]
    logic        m_tlast;

    hop_slot_t pending_slots[$];
    hop_slot_t next_slot;
    int        mismatch_count = 0;
    bit        tx_idle_en = 1'b1;
    bit        rx_idle_en = 1'b1;
    int        hold_len = 0;
    int        hold_requests = 0;

    hop_channel_list_generator_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Mostly short gaps, occasionally a long one.
    function automatic int gap_len();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(20, 60);
        return $urandom_range(1, 3);
    endfunction

    // Builds the hop list for one transmitter id and queues its slots.
    function automatic void predict_hop_list(input logic [31:0] tx_id);
        logic [31:0]     seed;
        logic [31:0]     lcg;
        logic [CH_W-1:0] chans [HOP_LENGTH];
        logic [CH_W-1:0] cand;
        int              filled;
        int              n_low;
        int              n_mid;
        int              n_high;
        bit              dup;
        bit              room;
        hop_slot_t       s;

        seed   = ~tx_id;
        lcg    = seed;
        filled = 0;
        while (filled < HOP_LENGTH)
        begin
            lcg  = lcg * LCG_MUL + LCG_ADD;
            cand = CH_W'((lcg >> 8) % CH_SPAN + CH_BASE);
            if (cand[0] != seed[0])
            begin
                n_low  = 0;
                n_mid  = 0;
                n_high = 0;
                dup    = 1'b0;
                for (int k = 0; k < filled; k++)
                begin
                    if (chans[k] == cand)
                        dup = 1'b1;
                    else if (chans[k] <= LOW_TOP)
                        n_low++;
                    else if (chans[k] <= MID_TOP)
                        n_mid++;
                    else
                        n_high++;
                end
                if (cand <= LOW_TOP)
                    room = n_low < OUTER_LIM;
                else if (cand <= MID_TOP)
                    room = n_mid < MID_LIM;
                else
                    room = n_high < OUTER_LIM;
                if (!dup && room)
                begin
                    chans[filled] = cand;
                    filled++;
                end
            end
        end
        for (int k = 0; k < HOP_LENGTH; k++)
        begin
            s.channel = chans[k];
            s.slot    = IDX_W'(k);
            s.last    = (k == HOP_LENGTH - 1);
            pending_slots.push_back(s);
        end
    endfunction

    task automatic flag_mismatch(input string what, input int want_v, input int got_v);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: %s: expected %0d, got %0d", $realtime, what, want_v, got_v);
    endtask

    // Output transaction checker
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_slots.size() == 0)
                flag_mismatch("unexpected hop slot, tdata", 0, m_tdata);
            else
            begin
                next_slot = pending_slots.pop_front();
                if (m_tdata[6:0] != next_slot.channel)
                    flag_mismatch("hop_channel", next_slot.channel, m_tdata[6:0]);
                if (m_tdata[11:7] != next_slot.slot)
                    flag_mismatch("slot_index", next_slot.slot, m_tdata[11:7]);
                if (m_tlast != next_slot.last)
                    flag_mismatch("last_slot", next_slot.last, m_tlast);
                if (m_tdata[15:12] != 4'd0)
                    flag_mismatch("tdata pad bits", 0, m_tdata[15:12]);
            end
        end
    end

    // Output ready: random stalls plus requested long hold-offs
    initial
    begin
        int holds_served;
        holds_served = 0;
        forever
        begin
            @(posedge clk);
            if (holds_served != hold_requests)
            begin
                holds_served = hold_requests;
                m_tready <= 1'b0;
                repeat (hold_len) @(posedge clk);
            end
            else if (rx_idle_en && $urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                repeat (gap_len()) @(posedge clk);
            end
            else
                m_tready <= 1'b1;
        end
    end

    task automatic send_id(input logic [31:0] tx_id);
        s_tvalid <= 1'b1;
        s_tdata  <= tx_id;
        do @(posedge clk); while (!s_tready);
        predict_hop_list(tx_id);
        if (tx_idle_en && $urandom_range(0, 2) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap_len()) @(posedge clk);
        end
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending_slots.size() != 0);
    endtask

    task automatic test_directed_ids();
        logic [31:0] ids [$];
        ids = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFE,
                32'h8000_0000, 32'h7FFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555,
                32'h1234_5678, 32'h8765_4321, 32'hFF00_FF00, 32'h00FF_00FF,
                32'h0102_0304, 32'hDEAD_BEEF, 32'hF0F0_F0F0, 32'h0F0F_0F0F,
                32'h0000_FFFF, 32'hFFFF_0000};
        foreach (ids[i])
            send_id(ids[i]);
        wait_drain();
    endtask

    task automatic test_random_ids();
        for (int i = 0; i < 67; i++)
            send_id($urandom());
        wait_drain();
    endtask

    task automatic test_back_to_back();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        for (int i = 0; i < 15; i++)
            send_id($urandom());
        wait_drain();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    // Output held off long enough that the unit stalls its input
    task automatic test_output_backpressure();
        tx_idle_en = 1'b0;
        hold_len = 800;
        hold_requests++;
        for (int i = 0; i < 4; i++)
            send_id($urandom());
        wait_drain();
        tx_idle_en = 1'b1;
    endtask

    // One list at a time, input idle until all slots are out
    task automatic test_drain_between_ids();
        for (int i = 0; i < 6; i++)
        begin
            send_id($urandom());
            wait_drain();
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_ids();
        test_random_ids();
        test_back_to_back();
        test_output_backpressure();
        test_drain_between_ids();
        repeat (50) @(posedge clk);
        if (mismatch_count == 0 && pending_slots.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #40_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
